[design/sprite_frame_sequencer_core_macros.svh]
// Assertion macros shared by the sprite frame sequencer design files.
// No dependencies; included by the top level where its checks are written.
`ifndef SPRITE_FRAME_SEQUENCER_CORE_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SFS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define SFS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sfs_pkg.sv]
// Package of the sprite frame sequencer: sizes, item kinds, play modes, register indexes.
// No dependencies; used by the channel interfaces and the top level.
package sfs_pkg;

  localparam int MAX_FRAMES    = 16;
  localparam int DURATION_BITS = 8;
  localparam int FRAME_W       = $clog2(MAX_FRAMES);
  localparam int CNT_W         = $clog2(MAX_FRAMES + 1);
  localparam int POS_W         = 12;
  localparam int ACC_W         = POS_W + 1;
  localparam int AMOUNT_W      = 8;
  localparam int KIND_W        = 2;
  localparam int SLOT_W        = 4;
  localparam int IDX_OUT_W     = 4;
  localparam int DUR_IN_W      = 8;
  localparam int PMODE_W       = 2;
  localparam int FCOUNT_W      = 5;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 5;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Item kinds carried in the mode field.
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // Play modes.
  localparam logic [PMODE_W-1:0] PM_STOP     = 2'd0;
  localparam logic [PMODE_W-1:0] PM_LOOP     = 2'd1;
  localparam logic [PMODE_W-1:0] PM_PINGPONG = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 4'd1;

endpackage

[design/sfs_channels.sv]
// Valid/ready channel interfaces of the sprite frame sequencer: input items,
// result items and configuration writes. Depends on sfs_pkg.
interface sfs_in_if import sfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   mode;
  logic [AMOUNT_W-1:0] amount;
  logic [SLOT_W-1:0]   frame_slot;
  logic [DUR_IN_W-1:0] duration;
  modport source (output valid, mode, amount, frame_slot, duration, input ready);
  modport sink   (input valid, mode, amount, frame_slot, duration, output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] frame_index;
  logic [POS_W-1:0]     position;
  logic                 reversing;
  modport source (output valid, frame_index, position, reversing, input ready);
  modport sink   (input valid, frame_index, position, reversing, output ready);
endinterface

interface sfs_cfg_if import sfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/sfs_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sprite_frame_sequencer_core.sv]
// Top level of the sprite frame sequencer: state machine, play-position update and
// the walk over the frame duration RAM. Depends on sfs_pkg, sfs_channels, sfs_ram.
//
//   channel   | dir | contents                                   | handshake
//   ----------+-----+--------------------------------------------+-----------
//   in_item   | in  | mode, amount, frame_slot, duration         | valid/ready
//   out_item  | out | frame_index, position, reversing           | valid/ready
//   cfg_wr    | in  | index, data (play_mode, frame_count)       | valid/ready
//
// An item goes through these steps, n being the frames in use (at most MAX_FRAMES): it is
// taken, the duration RAM is read n times, the last read returns, the walk is seen
// drained, and the result is handed over, which waits while the output register is full.
// Reset clears the position, the direction, the total and the registers; the
// duration RAM is not cleared and needs no clearing pass.
// A waiting result does not block the input: the next item is taken and walked, and
// only stalls at the hand-over until the output register is free.

`include "sprite_frame_sequencer_core_macros.svh"

module sprite_frame_sequencer_core import sfs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  sfs_in_if.sink   in_item,
  sfs_out_if.source out_item,
  sfs_cfg_if.sink  cfg_wr
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Architectural state.
  state_t                state_r, state_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  back_r, back_nxt;
  logic [POS_W-1:0]      total_r, total_nxt;
  logic [PMODE_W-1:0]    play_mode_r, play_mode_nxt;
  logic [FCOUNT_W-1:0]   frame_count_r, frame_count_nxt;

  // Walk over the duration RAM.
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  dvld_r, dvld_nxt;
  logic [FRAME_W-1:0]    pidx_r, pidx_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic                  sum_walk_r, sum_walk_nxt;
  logic                  found_r, found_nxt;
  logic [FRAME_W-1:0]    frame_r, frame_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0]  out_frame_r, out_frame_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic                  out_back_r, out_back_nxt;

  logic                      in_fire;
  logic                      cfg_fire;
  logic [CNT_W-1:0]          n_frames;
  logic                      rd_en;
  logic [FRAME_W-1:0]        rd_addr;
  logic [DURATION_BITS-1:0]  rd_data;
  logic                      ram_we;
  logic [ACC_W-1:0]          end_sum;

  // Position update of an advance item.
  logic [POS_W-1:0]      amt_ext;
  logic [POS_W-1:0]      amt_c;
  logic [ACC_W-1:0]      fwd_sum;
  logic [ACC_W-1:0]      total_ext;
  logic [ACC_W-1:0]      wrap_sum;
  logic [ACC_W-1:0]      reflect_sum;
  logic [POS_W-1:0]      adv_pos;
  logic                  adv_back;

  assign in_item.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign in_fire       = in_item.valid && in_item.ready;
  assign cfg_fire      = cfg_wr.valid && cfg_wr.ready;

  assign out_item.valid       = out_valid_r;
  assign out_item.frame_index = out_frame_r;
  assign out_item.position    = out_pos_r;
  assign out_item.reversing   = out_back_r;

  // A frame count above the table size acts as the table size.
  assign n_frames = (CNT_W'(frame_count_r) > CNT_W'(MAX_FRAMES)) ?
                    CNT_W'(MAX_FRAMES) : CNT_W'(frame_count_r);

  // Duration writes land in the RAM at the accepting edge; the walk reads start in the
  // following cycle, so a read never overlaps the write of the same item.
  assign ram_we  = in_fire && (in_item.mode == KIND_WRITE);
  assign rd_en   = (state_r == ST_WALK) && (cnt_r < n_frames);
  assign rd_addr = cnt_r[FRAME_W-1:0];

  sfs_ram #(
    .WIDTH (DURATION_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_dur_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_item.frame_slot[FRAME_W-1:0]),
    .wdata (in_item.duration[DURATION_BITS-1:0]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign end_sum = acc_r + ACC_W'(rd_data);

  // The advance amount is first cut to the total; afterwards every mode keeps the
  // position within [0, total].
  always_comb begin
    amt_ext     = POS_W'(in_item.amount);
    amt_c       = (amt_ext > total_r) ? total_r : amt_ext;
    total_ext   = ACC_W'(total_r);
    fwd_sum     = ACC_W'(pos_r) + ACC_W'(amt_c);
    wrap_sum    = fwd_sum - total_ext;
    reflect_sum = {total_r, 1'b0} - fwd_sum;
    adv_pos     = pos_r;
    adv_back    = back_r;
    case (play_mode_r)
      PM_STOP: begin
        adv_pos = (fwd_sum > total_ext) ? total_r : fwd_sum[POS_W-1:0];
      end
      PM_LOOP: begin
        adv_pos = (fwd_sum > total_ext) ? wrap_sum[POS_W-1:0] : fwd_sum[POS_W-1:0];
      end
      PM_PINGPONG: begin
        if (back_r) begin
          if (amt_c > pos_r) begin
            adv_back = 1'b0;
            adv_pos  = amt_c - pos_r;
          end else begin
            adv_pos  = pos_r - amt_c;
          end
        end else if (fwd_sum > total_ext) begin
          adv_back = 1'b1;
          adv_pos  = reflect_sum[POS_W-1:0];
        end else begin
          adv_pos  = fwd_sum[POS_W-1:0];
        end
      end
      default: begin
        adv_pos  = pos_r;
        adv_back = back_r;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    back_nxt        = back_r;
    total_nxt       = total_r;
    play_mode_nxt   = play_mode_r;
    frame_count_nxt = frame_count_r;
    cnt_nxt         = cnt_r;
    dvld_nxt        = rd_en;
    pidx_nxt        = rd_addr;
    acc_nxt         = acc_r;
    sum_walk_nxt    = sum_walk_r;
    found_nxt       = found_r;
    frame_nxt       = frame_r;
    out_valid_nxt   = out_valid_r && !out_item.ready;
    out_frame_nxt   = out_frame_r;
    out_pos_nxt     = out_pos_r;
    out_back_nxt    = out_back_r;

    // The user must send configuration writes only while no item is in flight; the block does not enforce it.
    if (cfg_fire) begin
      case (cfg_wr.index)
        REG_PLAY_MODE:   play_mode_nxt   = cfg_wr.data[PMODE_W-1:0];
        REG_FRAME_COUNT: frame_count_nxt = cfg_wr.data[FCOUNT_W-1:0];
        default: begin
          play_mode_nxt   = play_mode_r;
          frame_count_nxt = frame_count_r;
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt    = ST_WALK;
          cnt_nxt      = '0;
          acc_nxt      = '0;
          found_nxt    = 1'b0;
          frame_nxt    = '0;
          sum_walk_nxt = (in_item.mode == KIND_RESTART);
          case (in_item.mode)
            KIND_ADVANCE: begin
              pos_nxt  = adv_pos;
              back_nxt = adv_back;
            end
            KIND_RESTART: begin
              pos_nxt  = '0;
              back_nxt = 1'b0;
            end
            default: begin
              pos_nxt  = pos_r;
              back_nxt = back_r;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (dvld_r) begin
          if (sum_walk_r) begin
            // Restart total saturates at the largest position.
            acc_nxt = (end_sum > ACC_W'(POS_MAX)) ? ACC_W'(POS_MAX) : end_sum;
          end else begin
            acc_nxt = end_sum;
            if (!found_r && (ACC_W'(pos_r) > acc_r) && (ACC_W'(pos_r) <= end_sum)) begin
              found_nxt = 1'b1;
              frame_nxt = pidx_r;
            end
          end
        end
        // Once no read is issued and none is returning, the walk has seen every frame.
        if (!rd_en && !dvld_r) begin
          state_nxt = ST_DONE;
          if (sum_walk_r) begin
            total_nxt = acc_r[POS_W-1:0];
          end
        end
      end

      ST_DONE: begin
        // A restart leaves the position at zero, where the frame is always frame 0.
        if (!out_valid_r || out_item.ready) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_frame_nxt = IDX_OUT_W'(frame_r);
          out_pos_nxt   = pos_r;
          out_back_nxt  = back_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pos_r         <= '0;
      back_r        <= 1'b0;
      total_r       <= '0;
      play_mode_r   <= PM_STOP;
      frame_count_r <= FCOUNT_W'(1);
      cnt_r         <= '0;
      dvld_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      back_r        <= back_nxt;
      total_r       <= total_nxt;
      play_mode_r   <= play_mode_nxt;
      frame_count_r <= frame_count_nxt;
      cnt_r         <= cnt_nxt;
      dvld_r        <= dvld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    pidx_r       <= pidx_nxt;
    acc_r        <= acc_nxt;
    sum_walk_r   <= sum_walk_nxt;
    found_r      <= found_nxt;
    frame_r      <= frame_nxt;
    out_frame_r  <= out_frame_nxt;
    out_pos_r    <= out_pos_nxt;
    out_back_r   <= out_back_nxt;
  end

  // The position never leaves the window [0, total] in any play mode.
  `SFS_ASSERT_ALWAYS(a_pos_in_range, clk, rst_n, pos_r <= total_r,
                     "play position beyond total length")

  // A restart rewinds to position zero, running forward.
  `SFS_ASSERT_NEXT(a_restart_rewinds, clk, rst_n,
                   in_fire && (in_item.mode == KIND_RESTART),
                   (pos_r == '0) && !back_r,
                   "restart did not rewind the play position")

  // The walk has drained its RAM reads before the result is handed over.
  `SFS_ASSERT_SAME(a_done_drained, clk, rst_n, state_r == ST_DONE,
                   !dvld_r && !rd_en, "RAM read still pending at end of walk")

  // A new result appears only from the end of a walk.
  `SFS_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid_r),
                   $past(state_r == ST_DONE), "result produced outside the hand-over")

endmodule
